FILE: design/triangle_tangent_frame_defines.svh
// ----------------------------------------------------------------------------
// Triangle tangent frame: assertion macros
// Concurrent check macros, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_FRAME_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TTF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle rule");
// next-cycle implication
`define TTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle rule");
`else
`define TTF_ASSERT_NOW(lbl, ante, cons)
`define TTF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/ttf_pkg.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame package
// Shared types and constants.
// ----------------------------------------------------------------------------
package ttf_pkg;

    localparam int EPS_W      = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd17;
    localparam int PADDR_W    = 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // normalizer stage map
    localparam int SQ_FIRST   = 6;
    localparam int SQ_STEPS   = 32;
    localparam int DIV_FIRST  = SQ_FIRST + SQ_STEPS;
    localparam int DIV_STEPS  = 15;
    localparam int NORM_LAT   = DIV_FIRST + DIV_STEPS;

    typedef logic signed [20:0] edge_t;
    typedef logic signed [16:0] dtex_t;
    typedef logic signed [38:0] comp_t;
    typedef logic signed [15:0] unit_t;

    // one classified triangle, front to back
    typedef struct packed {
        edge_t [2:0] e1;
        edge_t [2:0] e2;
        dtex_t       du1;
        dtex_t       dv1;
        dtex_t       du2;
        dtex_t       dv2;
        logic        flip;
        logic        ok;
        logic        set;
    } item_t;

    typedef struct packed {
        logic valid;
        logic ok;
        logic set;
    } ctl_t;

    typedef struct packed {
        unit_t [2:0] tan;
        unit_t [2:0] bitan;
        logic        frame_valid;
        logic        set;
    } res_t;

endpackage

FILE: design/ttf_front.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame front end
// Takes requests, forms deltas and the UV determinant, classifies.
// ----------------------------------------------------------------------------
module ttf_front
    import ttf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [59:0]      pos_a,
    input  logic [59:0]      pos_b,
    input  logic [59:0]      pos_c,
    input  logic [31:0]      tex_a,
    input  logic [31:0]      tex_b,
    input  logic [31:0]      tex_c,
    input  logic             has_tex,
    input  logic             uv_set,
    input  logic [EPS_W-1:0] eps,
    output logic             push_valid,
    input  logic             push_ready,
    output item_t            push_item
);

    logic          f_valid_reg, f_valid_next;
    edge_t [2:0]   e1_reg, e2_reg;
    dtex_t         du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic          tex_reg, set_reg;
    logic          accept;

    logic signed [33:0] pr1, pr2;
    logic signed [34:0] det;
    logic        [34:0] adet;

    assign in_stall   = f_valid_reg && !push_ready;
    assign accept     = in_valid && !in_stall;
    assign push_valid = f_valid_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
            f_valid_next = 1'b1;
        else if (push_ready)
            f_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= edge_t'({pos_b[20*i+19], pos_b[20*i +: 20]})
                           - edge_t'({pos_a[20*i+19], pos_a[20*i +: 20]});
                e2_reg[i] <= edge_t'({pos_c[20*i+19], pos_c[20*i +: 20]})
                           - edge_t'({pos_a[20*i+19], pos_a[20*i +: 20]});
            end
            du1_reg <= dtex_t'({tex_b[15], tex_b[15:0]}) - dtex_t'({tex_a[15], tex_a[15:0]});
            dv1_reg <= dtex_t'({tex_b[31], tex_b[31:16]}) - dtex_t'({tex_a[31], tex_a[31:16]});
            du2_reg <= dtex_t'({tex_c[15], tex_c[15:0]}) - dtex_t'({tex_a[15], tex_a[15:0]});
            dv2_reg <= dtex_t'({tex_c[31], tex_c[31:16]}) - dtex_t'({tex_a[31], tex_a[31:16]});
            tex_reg <= has_tex;
            set_reg <= uv_set;
        end
    end

    // determinant and degenerate test
    always_comb
    begin
        pr1  = du1_reg * dv2_reg;
        pr2  = dv1_reg * du2_reg;
        det  = {pr1[33], pr1} - {pr2[33], pr2};
        adet = det[34] ? 35'(-det) : 35'(det);
        push_item.e1   = e1_reg;
        push_item.e2   = e2_reg;
        push_item.du1  = du1_reg;
        push_item.dv1  = dv1_reg;
        push_item.du2  = du2_reg;
        push_item.dv2  = dv2_reg;
        push_item.flip = det[34];
        push_item.ok   = tex_reg && (det != '0) && (adet >= {19'd0, eps});
        push_item.set  = set_reg;
    end

endmodule

FILE: design/ttf_queue.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module ttf_queue
    import ttf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_en,
    output item_t pop_item
);

    item_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_en;
    assign pop_item   = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push_item;
    end

endmodule

FILE: design/ttf_norm.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame normalizer
// Pipelined unit-vector unit: scale, square sum, root, three divides.
// ----------------------------------------------------------------------------
module ttf_norm
    import ttf_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  comp_t [2:0] vec,
    input  logic        flip,
    output unit_t [2:0] unit
);

    typedef struct packed {
        logic              zero;
        logic [2:0]        neg;
        logic [2:0][38:0]  mag;
        logic [38:0]       m;
        logic [5:0]        pos;
        logic [2:0][29:0]  nm;
        logic [2:0][59:0]  sq;
        logic [63:0]       s;
        logic [63:0]       r;
        logic [31:0]       len;
        logic [2:0][45:0]  rem;
        logic [2:0][14:0]  q;
    } nrm_t;

    nrm_t st_reg  [NORM_LAT];
    nrm_t st_next [NORM_LAT];

    // sign and magnitude
    always_comb
    begin
        st_next[0] = '0;
        for (int i = 0; i < 3; i++)
        begin
            st_next[0].neg[i] = vec[i][38] ^ flip;
            st_next[0].mag[i] = vec[i][38] ? 39'(-vec[i]) : 39'(vec[i]);
        end
    end

    // largest magnitude
    always_comb
    begin
        st_next[1]   = st_reg[0];
        st_next[1].m = st_reg[0].mag[0];
        if (st_reg[0].mag[1] > st_next[1].m)
            st_next[1].m = st_reg[0].mag[1];
        if (st_reg[0].mag[2] > st_next[1].m)
            st_next[1].m = st_reg[0].mag[2];
    end

    // leading one
    always_comb
    begin
        st_next[2]      = st_reg[1];
        st_next[2].zero = (st_reg[1].m == '0);
        st_next[2].pos  = '0;
        for (int b = 0; b < 39; b++)
            if (st_reg[1].m[b])
                st_next[2].pos = 6'(b);
    end

    // scale so the largest lies in [2^29, 2^30)
    always_comb
    begin
        st_next[3] = st_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            if (st_reg[2].pos > 6'd29)
                st_next[3].nm[i] = 30'(st_reg[2].mag[i] >> (st_reg[2].pos - 6'd29));
            else
                st_next[3].nm[i] = 30'(st_reg[2].mag[i] << (6'd29 - st_reg[2].pos));
        end
    end

    always_comb
    begin
        st_next[4] = st_reg[3];
        for (int i = 0; i < 3; i++)
            st_next[4].sq[i] = st_reg[3].nm[i] * st_reg[3].nm[i];
    end

    always_comb
    begin
        st_next[5]   = st_reg[4];
        st_next[5].s = 64'(st_reg[4].sq[0]) + 64'(st_reg[4].sq[1]) + 64'(st_reg[4].sq[2]);
        st_next[5].r = '0;
    end

    genvar k;
    generate
        // square root, one result bit per stage
        for (k = SQ_FIRST; k < DIV_FIRST; k++)
        begin : g_sqrt
            localparam int SH = 62 - 2 * (k - SQ_FIRST);
            logic [63:0] trial;
            always_comb
            begin
                trial      = st_reg[k-1].r + (64'd1 << SH);
                st_next[k] = st_reg[k-1];
                if (st_reg[k-1].s >= trial)
                begin
                    st_next[k].s = st_reg[k-1].s - trial;
                    st_next[k].r = (st_reg[k-1].r >> 1) + (64'd1 << SH);
                end
                else
                begin
                    st_next[k].r = st_reg[k-1].r >> 1;
                end
            end
        end

        // rounded divide by the length, one quotient bit per stage
        for (k = DIV_FIRST; k < NORM_LAT; k++)
        begin : g_div
            localparam int QB = DIV_STEPS - 1 - (k - DIV_FIRST);
            logic [31:0]      len_c;
            logic [2:0][45:0] rem_c;
            logic [45:0]      dd;
            always_comb
            begin
                st_next[k] = st_reg[k-1];
                if (k == DIV_FIRST)
                begin
                    len_c = st_reg[k-1].r[31:0];
                    for (int i = 0; i < 3; i++)
                        rem_c[i] = {2'b00, st_reg[k-1].nm[i], 14'd0} + 46'(len_c >> 1);
                    st_next[k].q = '0;
                end
                else
                begin
                    len_c = st_reg[k-1].len;
                    rem_c = st_reg[k-1].rem;
                end
                st_next[k].len = len_c;
                dd = 46'(len_c) << QB;
                for (int i = 0; i < 3; i++)
                begin
                    st_next[k].rem[i] = rem_c[i];
                    if (rem_c[i] >= dd)
                    begin
                        st_next[k].rem[i]  = rem_c[i] - dd;
                        st_next[k].q[i][QB] = 1'b1;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NORM_LAT; s++)
                st_reg[s] <= st_next[s];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (st_reg[NORM_LAT-1].zero)
                unit[i] = '0;
            else if (st_reg[NORM_LAT-1].neg[i])
                unit[i] = -unit_t'({1'b0, st_reg[NORM_LAT-1].q[i]});
            else
                unit[i] = unit_t'({1'b0, st_reg[NORM_LAT-1].q[i]});
        end
    end

endmodule

FILE: design/ttf_back.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame back end
// Edge products, two normalizers and the output register.
// ----------------------------------------------------------------------------
module ttf_back
    import ttf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  pop_valid,
    output logic  pop_en,
    input  item_t pop_item,
    output logic  out_valid,
    input  logic  out_stall,
    output res_t  res
);

    logic               adv;
    logic signed [37:0] p1_reg [3];
    logic signed [37:0] p2_reg [3];
    logic signed [37:0] p3_reg [3];
    logic signed [37:0] p4_reg [3];
    logic               flip_reg;
    ctl_t               b1_ctl_reg;
    ctl_t               ctl_reg [NORM_LAT];
    comp_t [2:0]        t_vec, b_vec;
    unit_t [2:0]        t_unit, b_unit;
    logic               out_valid_reg;
    res_t               res_reg;

    // whole back pipe moves unless the output register is full and stalled
    assign adv       = !out_valid_reg || !out_stall;
    assign pop_en    = adv;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= pop_item.e1[i] * pop_item.dv2;
                p2_reg[i] <= pop_item.e2[i] * pop_item.dv1;
                p3_reg[i] <= pop_item.e2[i] * pop_item.du1;
                p4_reg[i] <= pop_item.e1[i] * pop_item.du2;
            end
            flip_reg <= pop_item.flip;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_vec[i] = {p1_reg[i][37], p1_reg[i]} - {p2_reg[i][37], p2_reg[i]};
            b_vec[i] = {p3_reg[i][37], p3_reg[i]} - {p4_reg[i][37], p4_reg[i]};
        end
    end

    ttf_norm u_norm_t (
        .clk  (clk),
        .en   (adv),
        .vec  (t_vec),
        .flip (flip_reg),
        .unit (t_unit)
    );

    ttf_norm u_norm_b (
        .clk  (clk),
        .en   (adv),
        .vec  (b_vec),
        .flip (flip_reg),
        .unit (b_unit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_ctl_reg <= '0;
            for (int s = 0; s < NORM_LAT; s++)
                ctl_reg[s] <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_ctl_reg.valid <= pop_valid;
            b1_ctl_reg.ok    <= pop_item.ok;
            b1_ctl_reg.set   <= pop_item.set;
            ctl_reg[0]       <= b1_ctl_reg;
            for (int s = 1; s < NORM_LAT; s++)
                ctl_reg[s] <= ctl_reg[s-1];
            out_valid_reg <= ctl_reg[NORM_LAT-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.tan         <= ctl_reg[NORM_LAT-1].ok ? t_unit : '0;
            res_reg.bitan       <= ctl_reg[NORM_LAT-1].ok ? b_unit : '0;
            res_reg.frame_valid <= ctl_reg[NORM_LAT-1].ok;
            res_reg.set         <= ctl_reg[NORM_LAT-1].set;
        end
    end

endmodule

FILE: design/triangle_tangent_frame.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame
// Unit tangent and bitangent of a textured triangle, Q1.14 output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one triangle request: three
//   Q8.12 positions, three Q4.12 texcoords, has_tex and uv_set. A request is
//   taken on a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   request, in order: tangent, bitangent, frame_valid and set_out.
//   From the accepting edge to out_valid a request passes the front register,
//   queue, product stage, 53 normalizer stages (32 of them are the
//   square-root bit steps, 15 the quotient bit steps) and output register.
//   Throughput is one request per cycle while in_stall stays low.
//   A four-entry queue splits the front end from the back end. When the
//   receiver stalls, the back pipe freezes, the queue fills, then in_stall
//   rises; nothing is lost or repeated.
//   Reset clears all valid flags and loads det_epsilon with 17.
//   det_epsilon sits at APB byte address 0; write it only while idle.
// ----------------------------------------------------------------------------
`include "triangle_tangent_frame_defines.svh"

module triangle_tangent_frame
    import ttf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [59:0]        pos_a,
    input  logic [59:0]        pos_b,
    input  logic [59:0]        pos_c,
    input  logic [31:0]        tex_a,
    input  logic [31:0]        tex_b,
    input  logic [31:0]        tex_c,
    input  logic               has_tex,
    input  logic               uv_set,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] tan_x,
    output logic signed [15:0] tan_y,
    output logic signed [15:0] tan_z,
    output logic signed [15:0] bitan_x,
    output logic signed [15:0] bitan_y,
    output logic signed [15:0] bitan_z,
    output logic               frame_valid,
    output logic               set_out
);

    logic [EPS_W-1:0] eps_reg;
    logic             cfg_wr;

    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_en;
    item_t pop_item;
    res_t  res;

    // single register, det_epsilon at byte address 0
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = {16'd0, eps_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_wr && (paddr == '0))
            eps_reg <= pwdata[EPS_W-1:0];
    end

    // front: accept, deltas, determinant, classify
    ttf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pos_a      (pos_a),
        .pos_b      (pos_b),
        .pos_c      (pos_c),
        .tex_a      (tex_a),
        .tex_b      (tex_b),
        .tex_c      (tex_c),
        .has_tex    (has_tex),
        .uv_set     (uv_set),
        .eps        (eps_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ttf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_item   (pop_item)
    );

    // back: products, normalizers, output register
    ttf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_en    (pop_en),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign tan_x       = res.tan[0];
    assign tan_y       = res.tan[1];
    assign tan_z       = res.tan[2];
    assign bitan_x     = res.bitan[0];
    assign bitan_y     = res.bitan[1];
    assign bitan_z     = res.bitan[2];
    assign frame_valid = res.frame_valid;
    assign set_out     = res.set;

    // rejected triangles come out as all-zero vectors
    `TTF_ASSERT_NOW(a_reject_zero, out_valid && !frame_valid,
        tan_x == 16'sd0 && tan_y == 16'sd0 && tan_z == 16'sd0 &&
        bitan_x == 16'sd0 && bitan_y == 16'sd0 && bitan_z == 16'sd0)
    // tangent and bitangent x components never exceed one
    `TTF_ASSERT_NOW(a_unit_range, out_valid && frame_valid,
        tan_x <= 16'sd16384 && tan_x >= -16'sd16384 &&
        bitan_x <= 16'sd16384 && bitan_x >= -16'sd16384)
    // input back-pressure only when the queue is full
    `TTF_ASSERT_NOW(a_stall_full, in_stall, !push_ready && push_valid)
    // a full queue with a frozen back end stays full
    `TTF_ASSERT_NEXT(a_queue_hold, !push_ready && out_valid && out_stall, !push_ready)

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame testbench
// Drives triangle requests with random gaps and stalls, predicts each frame
// in-line, and compares every result field against the predicted queue.
// ----------------------------------------------------------------------------
module testbench;
    import ttf_pkg::*;

    localparam int LATENCY  = 56;
    localparam logic [PADDR_W-1:0] ADDR_DET_EPS = '0;

    typedef struct packed {
        logic [59:0] pa;
        logic [59:0] pb;
        logic [59:0] pc;
        logic [31:0] ta;
        logic [31:0] tb;
        logic [31:0] tc;
        logic        has;
        logic        set;
    } tri_req_t;

    typedef struct packed {
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] tz;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] bz;
        logic        fv;
        logic        so;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [59:0] pos_a = '0, pos_b = '0, pos_c = '0;
    logic [31:0] tex_a = '0, tex_b = '0, tex_c = '0;
    logic has_tex = 1'b0, uv_set = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z;
    logic frame_valid, set_out;

    // predictor copy of the threshold register
    logic [15:0] eps_shadow = EPS_RESET;
    frame_t      frames_due[$];
    int          mismatches = 0;
    bit          calm = 1'b0;        // no random idling while set
    int          hold_cycles = 0;    // long receiver hold-off in progress

    always #5 clk = ~clk;

    triangle_tangent_frame DUT (.*);

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint sx(logic [63:0] v, int w);
        logic [63:0] m;
        m = 64'(1) << (w - 1);
        v = v & ((64'(1) << w) - 1);
        return longint'((v ^ m) - m);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'(1) << 62;
        while (b > s) b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in Q1.14; all-zero input gives zeros
    function automatic logic [47:0] unit_q14(longint c0, longint c1, longint c2, bit flip);
        longint c[3];
        longint unsigned mag[3], mx, s, len, q;
        bit neg[3];
        logic [47:0] res;
        c[0] = c0; c[1] = c1; c[2] = c2;
        mx = 0;
        s = 0;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = (c[i] < 0) != flip;
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) return res;
        while (mx >= (64'(1) << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (mx < (64'(1) << 29))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
        len = root_floor(s);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * 16384 + (len >> 1)) / len;
            res[16*i +: 16] = neg[i] ? 16'(-q) : 16'(q);
        end
        return res;
    endfunction

    function automatic frame_t predict_frame(tri_req_t r);
        frame_t f;
        longint p[3][3], u[3], v[3];
        longint du1, dv1, du2, dv2, det, adet, e1, e2;
        longint t[3], b[3];
        logic [59:0] pp[3];
        logic [31:0] tt[3];
        logic [47:0] tv, bv;
        f = '0;
        f.so = r.set;
        if (!r.has) return f;
        pp[0] = r.pa; pp[1] = r.pb; pp[2] = r.pc;
        tt[0] = r.ta; tt[1] = r.tb; tt[2] = r.tc;
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++) p[k][i] = sx(64'(pp[k] >> (20*i)), 20);
            u[k] = sx(64'(tt[k]), 16);
            v[k] = sx(64'(tt[k] >> 16), 16);
        end
        du1 = u[1] - u[0]; dv1 = v[1] - v[0];
        du2 = u[2] - u[0]; dv2 = v[2] - v[0];
        det = du1 * dv2 - dv1 * du2;
        adet = det < 0 ? -det : det;
        if (det == 0 || adet < longint'(eps_shadow)) return f;
        for (int i = 0; i < 3; i++)
        begin
            e1 = p[1][i] - p[0][i];
            e2 = p[2][i] - p[0][i];
            t[i] = e1 * dv2 - e2 * dv1;
            b[i] = e2 * du1 - e1 * du2;
        end
        tv = unit_q14(t[0], t[1], t[2], det < 0);
        bv = unit_q14(b[0], b[1], b[2], det < 0);
        {f.tz, f.ty, f.tx} = tv;
        {f.bz, f.by, f.bx} = bv;
        f.fv = 1'b1;
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off while hold_cycles > 0
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 13);
    end

    // result checker: compares each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        frame_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, frame_valid, set_out};
            if (frames_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = frames_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("frame mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------------
    // valid stays high from one request to the next unless an idle cycle falls
    task automatic send_request(tri_req_t r);
        while (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {pos_a, pos_b, pos_c, tex_a, tex_b, tex_c, has_tex, uv_set} <= r;
        frames_due = {frames_due, predict_frame(r)};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_det_eps(logic [15:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_DET_EPS; pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        eps_shadow = val;
        @(posedge clk);
    endtask

    // random vertex coordinate: sometimes extreme or small, usually fully random
    function automatic logic [19:0] rnd_coord();
        case ($urandom_range(7))
            0: return 20'h7FFFF;
            1: return 20'h80000;
            2: return 20'(int'($urandom_range(64)) - 32);
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rnd_uv();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tri_req_t rnd_tri();
        tri_req_t r;
        r.pa = {rnd_coord(), rnd_coord(), rnd_coord()};
        r.pb = {rnd_coord(), rnd_coord(), rnd_coord()};
        r.pc = {rnd_coord(), rnd_coord(), rnd_coord()};
        r.ta = {rnd_uv(), rnd_uv()};
        r.tb = {rnd_uv(), rnd_uv()};
        r.tc = {rnd_uv(), rnd_uv()};
        // mostly textured so the frame math gets exercised
        r.has = ($urandom_range(9) != 0);
        r.set = $urandom_range(1);
        // collapsed UV or positions now and then
        if ($urandom_range(19) == 0) r.tc = r.ta;
        if ($urandom_range(19) == 0) r.pb = r.pa;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        tri_req_t r;
        // unit right triangle, plain UV
        r = '0;
        r.pb = 60'h1000; r.pc = 60'(20'h1000) << 20;
        r.tb = 32'h0000_1000; r.tc = 32'h1000_0000;
        r.has = 1'b1;
        send_request(r);
        // same with texture absent, second set
        r.has = 1'b0; r.set = 1'b1;
        send_request(r);
        // mirrored UV: negative determinant
        r.has = 1'b1; r.tb = 32'h0000_F000;
        send_request(r);
        // zero determinant
        r.tc = r.tb;
        send_request(r);
        // tiny determinant around the reset threshold (det = 16, 17)
        r.tb = 32'h0000_0004; r.tc = 32'h0004_0000;
        send_request(r);
        r.tc = 32'h0004_0000; r.tb = 32'h0000_0004; r.ta = '0;
        r.tb = 32'h0000_0011; r.tc = 32'h0001_0000;
        send_request(r);
        // collapsed positions: zero tangent and bitangent, frame still valid
        r.pb = '0; r.pc = '0;
        send_request(r);
        // extreme positions and texcoords
        r.pa = {3{20'h80000}}; r.pb = {3{20'h7FFFF}}; r.pc = {20'h7FFFF, 20'h80000, 20'h00001};
        r.ta = 32'h8000_8000; r.tb = 32'h7FFF_7FFF; r.tc = 32'h8000_7FFF;
        send_request(r);
        r.ta = 32'h7FFF_7FFF; r.tb = 32'h8000_8000; r.tc = 32'h7FFF_8000; r.set = 1'b0;
        send_request(r);
        r = '1;
        send_request(r);
        for (int i = 0; i < 10; i++) send_request(rnd_tri());
        drain();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_request(rnd_tri());
        drain();
    endtask

    // receiver holds off long enough that the queue fills and in_stall rises
    task automatic test_backpressure();
        hold_cycles = 200;
        for (int i = 0; i < 120; i++) send_request(rnd_tri());
        drain();
    endtask

    // no idling on either side: back-to-back stream
    task automatic test_streaming();
        calm = 1'b1;
        for (int i = 0; i < 250; i++) send_request(rnd_tri());
        calm = 1'b0;
        drain();
    endtask

    task automatic test_thresholds();
        write_det_eps(16'd0);
        test_random(150);
        write_det_eps(16'hFFFF);
        test_random(150);
        write_det_eps(16'd1);
        test_random(150);
        write_det_eps(16'(1 + $urandom_range(4095)));
        test_random(150);
        write_det_eps(EPS_RESET);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        test_backpressure();
        test_streaming();
        test_thresholds();
        if (mismatches == 0 && frames_due.size() == 0)
            $display("triangle_tangent_frame test passed");
        else
            $display("triangle_tangent_frame test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("triangle_tangent_frame test failed");
        $finish;
    end

endmodule
